// ===== hdl/smld_pkg.sv =====
// Shared constants and types for the sine-modulated LED duty core.
package smld_pkg;

	// Time and period widths
	localparam int TIME_W     = 63;
	localparam int PERIOD_W   = 16;
	localparam int PER_W      = 26;   // period in microseconds, up to 65535 * 1000
	localparam int MS_TO_US   = 1000;
	localparam int FRAC_W     = 16;

	// Defaults for the top-level parameters
	localparam int DUTY_BITS_DEF  = 13;
	localparam int PHASE_BITS_DEF = 10;

	// Q30 constants of the sine series
	localparam logic [30:0] Q30_ONE  = 31'h4000_0000;
	localparam logic [30:0] Q30_HALF = 31'h2000_0000;
	localparam logic [30:0] SIN_C1   = 31'd1686629713;
	localparam logic [30:0] SIN_C3   = 31'd693598668;
	localparam logic [30:0] SIN_C5   = 31'd85569306;
	localparam logic [30:0] SIN_C7   = 31'd5026995;
	localparam logic [30:0] SIN_C9   = 31'd172272;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_DUTY_LEVEL = 2'd0,
		REG_PERIOD_MS  = 2'd1,
		REG_SINE_MODE  = 2'd2
	} cfg_reg_t;

endpackage

// ===== hdl/smld_rdiv.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
module smld_rdiv #(
	parameter int N = smld_pkg::TIME_W,
	parameter int W = smld_pkg::PER_W
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         src_valid,
	input  logic [N-1:0] src_word,
	input  logic [W-1:0] src_rem,
	input  logic [W-1:0] divisor,
	output logic         dst_valid,
	output logic [N-1:0] dst_word,
	output logic [W-1:0] dst_rem
);

	// Per-stage registers: remaining dividend bits shift out at the top while
	// quotient bits shift in at the bottom
	logic         valid_s [N];
	logic [N-1:0] word_s  [N];
	logic [W-1:0] rem_s   [N];

	genvar k;
	for (k = 0; k < N; k++) begin : g_step
		logic         vld_i;
		logic [N-1:0] word_i;
		logic [W-1:0] rem_i;
		logic [W:0]   trial;
		logic [W:0]   diff;
		logic         ge;

		if (k == 0) begin : g_first
			assign vld_i  = src_valid;
			assign word_i = src_word;
			assign rem_i  = src_rem;
		end else begin : g_next
			assign vld_i  = valid_s[k-1];
			assign word_i = word_s[k-1];
			assign rem_i  = rem_s[k-1];
		end

		// One compare and subtract per stage
		assign trial = {rem_i, word_i[N-1]};
		assign ge    = (trial >= {1'b0, divisor});
		assign diff  = trial - {1'b0, divisor};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (en) begin
				valid_s[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				word_s[k] <= {word_i[N-2:0], ge};
				rem_s[k]  <= ge ? diff[W-1:0] : trial[W-1:0];
			end
		end
	end

	assign dst_valid = valid_s[N-1];
	assign dst_word  = word_s[N-1];
	assign dst_rem   = rem_s[N-1];

endmodule

// ===== hdl/smld_sin.sv =====
// Pipelined sine fraction: phase index to 16-bit 0.5 + 0.5*sin value.
module smld_sin #(
	parameter int PHASE_BITS = smld_pkg::PHASE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        src_valid,
	input  logic [PHASE_BITS-1:0]       src_index,
	output logic                        dst_valid,
	output logic [smld_pkg::FRAC_W-1:0] dst_frac
);

	localparam int PadW = 32 - PHASE_BITS;

	// Q30 product with truncation
	function automatic logic [30:0] mul_q30(input logic [30:0] a, input logic [30:0] b);
		logic [61:0] p;
		p = a * b;
		return p[60:30];
	endfunction

	logic        valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic        valid_s6, valid_s7, valid_s8, valid_s9, valid_s10;
	logic [1:0]  quad_s1, quad_s2, quad_s3, quad_s4, quad_s5, quad_s6, quad_s7, quad_s8, quad_s9;
	logic [30:0] t_s1, t_s2;
	logic [30:0] t2_s2, t2_s3, t2_s4, t2_s5;
	logic [30:0] t3_s3, t5_s4, t7_s5, t9_s6;
	logic [30:0] c1t_s2, c1t_s3, c1t_s4, c1t_s5, c1t_s6;
	logic [30:0] c3t_s4, c3t_s5, c3t_s6;
	logic [30:0] c5t_s5, c5t_s6;
	logic [30:0] c7t_s6;
	logic [31:0] pp_s7, neg_s7, neg_s8;
	logic [30:0] c9t_s7;
	logic [31:0] pos_s8;
	logic [30:0] s_s9;
	logic [smld_pkg::FRAC_W-1:0] frac_s10;

	// Quadrant fold of the phase
	logic [29:0] t_raw;
	logic [30:0] t_fold;
	assign t_raw  = {src_index[PHASE_BITS-3:0], {PadW{1'b0}}};
	assign t_fold = src_index[PHASE_BITS-2] ? (smld_pkg::Q30_ONE - {1'b0, t_raw})
	                                        : {1'b0, t_raw};

	// Difference and clamp of the series sums
	logic [31:0] s_diff;
	logic [30:0] s_clamp;
	assign s_diff  = (pos_s8 > neg_s8) ? (pos_s8 - neg_s8) : 32'd0;
	assign s_clamp = (s_diff > {1'b0, smld_pkg::Q30_ONE}) ? smld_pkg::Q30_ONE : s_diff[30:0];

	// Offset around one half, scale to 16 bits with saturation
	logic [30:0] v_w;
	assign v_w = quad_s9[1] ? (smld_pkg::Q30_HALF - {1'b0, s_s9[30:1]})
	                        : (smld_pkg::Q30_HALF + {1'b0, s_s9[30:1]});

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			valid_s4  <= 1'b0;
			valid_s5  <= 1'b0;
			valid_s6  <= 1'b0;
			valid_s7  <= 1'b0;
			valid_s8  <= 1'b0;
			valid_s9  <= 1'b0;
			valid_s10 <= 1'b0;
		end else if (en) begin
			valid_s1  <= src_valid;
			valid_s2  <= valid_s1;
			valid_s3  <= valid_s2;
			valid_s4  <= valid_s3;
			valid_s5  <= valid_s4;
			valid_s6  <= valid_s5;
			valid_s7  <= valid_s6;
			valid_s8  <= valid_s7;
			valid_s9  <= valid_s8;
			valid_s10 <= valid_s9;
		end
	end

	// Datapath: one multiply deep per stage
	always_ff @(posedge clk) begin
		if (en) begin
			// fold
			t_s1    <= t_fold;
			quad_s1 <= src_index[PHASE_BITS-1:PHASE_BITS-2];
			// t^2, C1*t
			t2_s2   <= mul_q30(t_s1, t_s1);
			c1t_s2  <= mul_q30(smld_pkg::SIN_C1, t_s1);
			t_s2    <= t_s1;
			quad_s2 <= quad_s1;
			// t^3
			t3_s3   <= mul_q30(t_s2, t2_s2);
			t2_s3   <= t2_s2;
			c1t_s3  <= c1t_s2;
			quad_s3 <= quad_s2;
			// t^5, C3*t^3
			t5_s4   <= mul_q30(t3_s3, t2_s3);
			c3t_s4  <= mul_q30(smld_pkg::SIN_C3, t3_s3);
			t2_s4   <= t2_s3;
			c1t_s4  <= c1t_s3;
			quad_s4 <= quad_s3;
			// t^7, C5*t^5
			t7_s5   <= mul_q30(t5_s4, t2_s4);
			c5t_s5  <= mul_q30(smld_pkg::SIN_C5, t5_s4);
			t2_s5   <= t2_s4;
			c1t_s5  <= c1t_s4;
			c3t_s5  <= c3t_s4;
			quad_s5 <= quad_s4;
			// t^9, C7*t^7
			t9_s6   <= mul_q30(t7_s5, t2_s5);
			c7t_s6  <= mul_q30(smld_pkg::SIN_C7, t7_s5);
			c1t_s6  <= c1t_s5;
			c3t_s6  <= c3t_s5;
			c5t_s6  <= c5t_s5;
			quad_s6 <= quad_s5;
			// C9*t^9, partial sums
			c9t_s7  <= mul_q30(smld_pkg::SIN_C9, t9_s6);
			pp_s7   <= {1'b0, c1t_s6} + {1'b0, c5t_s6};
			neg_s7  <= {1'b0, c3t_s6} + {1'b0, c7t_s6};
			quad_s7 <= quad_s6;
			// positive sum
			pos_s8  <= pp_s7 + {1'b0, c9t_s7};
			neg_s8  <= neg_s7;
			quad_s8 <= quad_s7;
			// clamped sine magnitude
			s_s9    <= s_clamp;
			quad_s9 <= quad_s8;
			// fraction
			frac_s10 <= v_w[30] ? {smld_pkg::FRAC_W{1'b1}} : v_w[29:14];
		end
	end

	assign dst_valid = valid_s10;
	assign dst_frac  = frac_s10;

endmodule

// ===== hdl/sine_modulated_led_duty_core.sv =====
// Top level of the sine-modulated LED duty core.
// Usage:
//   Item channel (item_valid/item_stall, time_us) takes one time stamp in
//   microseconds per transaction; the duty channel (duty_valid/duty_stall,
//   duty) returns one duty word per transaction, in order.
//   Configuration is a plain write port (cfg_wen, cfg_idx, cfg_data):
//   index 0 duty level, 1 period in ms, 2 sine mode enable. Write only while
//   no transaction is in flight; the period is turned into microseconds on
//   the write itself.
// Throughput: one transaction per cycle while the skid register is empty,
//   every stage holds one item. Pipeline: 63 modulo stages (one time bit
//   each), PHASE_BITS phase-division stages, ten sine series stages and
//   the output register.
// Reset: all valid bits clear, configuration registers return to zero
//   (constant mode, level zero).
// Stall: the output register is backed by a skid register; while the skid
//   register holds a transaction the whole pipeline freezes and item_stall
//   is high, so nothing is dropped or repeated.
module sine_modulated_led_duty_core #(
	parameter int DUTY_BITS  = smld_pkg::DUTY_BITS_DEF,
	parameter int PHASE_BITS = smld_pkg::PHASE_BITS_DEF,
	localparam int CfgW = (DUTY_BITS > smld_pkg::PERIOD_W) ? DUTY_BITS : smld_pkg::PERIOD_W
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration
	input  logic                        cfg_wen,
	input  logic [1:0]                  cfg_idx,
	input  logic [CfgW-1:0]             cfg_data,
	// items
	input  logic                        item_valid,
	output logic                        item_stall,
	input  logic [smld_pkg::TIME_W-1:0] time_us,
	// results
	output logic                        duty_valid,
	input  logic                        duty_stall,
	output logic [DUTY_BITS-1:0]        duty
);

	localparam int PerW  = smld_pkg::PER_W;
	localparam int FracW = smld_pkg::FRAC_W;

	// Configuration registers
	logic [DUTY_BITS-1:0] level_q;
	logic [PerW-1:0]      per_us_q;
	logic                 sine_mode_q;
	logic [PerW-1:0]      per_us_w;

	assign per_us_w = {{(PerW - smld_pkg::PERIOD_W){1'b0}}, cfg_data[smld_pkg::PERIOD_W-1:0]}
	                  * PerW'(smld_pkg::MS_TO_US);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q     <= '0;
			per_us_q    <= '0;
			sine_mode_q <= 1'b0;
		end else if (cfg_wen) begin
			unique case (smld_pkg::cfg_reg_t'(cfg_idx))
				smld_pkg::REG_DUTY_LEVEL: level_q     <= cfg_data[DUTY_BITS-1:0];
				smld_pkg::REG_PERIOD_MS:  per_us_q    <= per_us_w;
				smld_pkg::REG_SINE_MODE:  sine_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Pipeline advance: frozen while the skid register is occupied
	logic skid_valid_q;
	logic adv;
	assign adv        = !skid_valid_q;
	assign item_stall = skid_valid_q;

	// Time modulo period
	logic            mod_valid;
	logic [PerW-1:0] mod_rem;

	smld_rdiv #(
		.N(smld_pkg::TIME_W),
		.W(PerW)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.src_valid(item_valid),
		.src_word (time_us),
		.src_rem  ({PerW{1'b0}}),
		.divisor  (per_us_q),
		.dst_valid(mod_valid),
		.dst_word (),
		.dst_rem  (mod_rem)
	);

	// Phase index = (rem << PHASE_BITS) / period
	logic                  idx_valid;
	logic [PHASE_BITS-1:0] idx;

	smld_rdiv #(
		.N(PHASE_BITS),
		.W(PerW)
	) u_phase (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.src_valid(mod_valid),
		.src_word ({PHASE_BITS{1'b0}}),
		.src_rem  (mod_rem),
		.divisor  (per_us_q),
		.dst_valid(idx_valid),
		.dst_word (idx),
		.dst_rem  ()
	);

	// Sine fraction
	logic             frac_valid;
	logic [FracW-1:0] frac;

	smld_sin #(
		.PHASE_BITS(PHASE_BITS)
	) u_sin (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.src_valid(idx_valid),
		.src_index(idx),
		.dst_valid(frac_valid),
		.dst_frac (frac)
	);

	// Level scaling, constant level when not modulating
	logic [DUTY_BITS+FracW-1:0] prod;
	logic [DUTY_BITS-1:0]       duty_w;
	assign prod   = {{FracW{1'b0}}, level_q} * {{DUTY_BITS{1'b0}}, frac};
	assign duty_w = (sine_mode_q && (per_us_q != '0)) ? prod[DUTY_BITS+FracW-1:FracW] : level_q;

	// Output register and skid register
	logic                 duty_valid_q;
	logic [DUTY_BITS-1:0] duty_q;
	logic [DUTY_BITS-1:0] skid_q;
	logic                 out_free;
	assign out_free = !duty_valid_q || !duty_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_free) begin
				duty_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (out_free) begin
			duty_valid_q <= frac_valid;
		end else if (frac_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_free) begin
				duty_q <= skid_q;
			end
		end else if (out_free) begin
			duty_q <= duty_w;
		end else begin
			skid_q <= duty_w;
		end
	end

	assign duty_valid = duty_valid_q;
	assign duty       = duty_q;

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking bench for the sine-modulated LED duty core: random and directed time stamps.
module tb_top;
	import smld_pkg::*;

	localparam int DUTY_W    = DUTY_BITS_DEF;
	localparam int PH_W      = PHASE_BITS_DEF;
	localparam int CFG_W     = PERIOD_W;
	localparam int LATENCY   = 73 + PH_W;
	localparam int LONG_HOLD = 300;
	localparam logic [1:0] REG_NONE = 2'd3;   // not decoded, writes must be dropped

	// Expected duty words, worked out from the time stamp and the current registers
	class duty_scoreboard;
		logic [DUTY_W-1:0]   cfg_level;
		logic [PERIOD_W-1:0] cfg_period_ms;
		logic                cfg_sine;
		logic [DUTY_W-1:0]   duty_fifo[$];
		int                  errors;
		int                  checked;

		function new();
			cfg_level     = '0;
			cfg_period_ms = '0;
			cfg_sine      = 1'b0;
			errors        = 0;
			checked       = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_DUTY_LEVEL: cfg_level = data[DUTY_W-1:0];
				REG_PERIOD_MS:  cfg_period_ms = data[PERIOD_W-1:0];
				REG_SINE_MODE:  cfg_sine = data[0];
				default: ;
			endcase
		endfunction

		function logic [63:0] q30_mul(logic [63:0] a, logic [63:0] b);
			return (a * b) >> 30;
		endfunction

		// 16-bit fraction of 0.5 + 0.5*sin(2*pi*ph/2^PH_W), odd series in Q30
		function logic [FRAC_W-1:0] sine_frac(logic [PH_W-1:0] ph);
			logic [31:0] u;
			logic [1:0]  quad;
			logic [63:0] t, t2, t3, t5, t7, t9, pos, neg, s, v;
			u    = 32'(ph) << (32 - PH_W);
			quad = u[31:30];
			t    = {34'd0, u[29:0]};
			if (quad[0]) begin
				t = 64'(Q30_ONE) - t;
			end
			t2  = q30_mul(t, t);
			t3  = q30_mul(t, t2);
			t5  = q30_mul(t3, t2);
			t7  = q30_mul(t5, t2);
			t9  = q30_mul(t7, t2);
			pos = q30_mul(64'(SIN_C1), t) + q30_mul(64'(SIN_C5), t5) + q30_mul(64'(SIN_C9), t9);
			neg = q30_mul(64'(SIN_C3), t3) + q30_mul(64'(SIN_C7), t7);
			s   = (pos > neg) ? pos - neg : 64'd0;
			if (s > 64'(Q30_ONE)) begin
				s = 64'(Q30_ONE);
			end
			if (quad[1]) begin
				v = 64'(Q30_HALF) - (s >> 1);
			end else begin
				v = 64'(Q30_HALF) + (s >> 1);
			end
			v = v >> 14;
			if (v > 64'd65535) begin
				v = 64'd65535;
			end
			return v[FRAC_W-1:0];
		endfunction

		function logic [DUTY_W-1:0] predict_duty(logic [TIME_W-1:0] t_us);
			logic [63:0] per_us, r, ph, d;
			d = 64'(cfg_level);
			if (cfg_sine && cfg_period_ms != 0) begin
				per_us = 64'(cfg_period_ms) * MS_TO_US;
				r      = 64'(t_us) % per_us;
				ph     = (r << PH_W) / per_us;
				d      = (64'(cfg_level) * 64'(sine_frac(ph[PH_W-1:0]))) >> FRAC_W;
			end
			return d[DUTY_W-1:0];
		endfunction

		function void note_item(logic [TIME_W-1:0] t_us);
			duty_fifo.push_back(predict_duty(t_us));
		endfunction

		function void check_duty(logic [DUTY_W-1:0] got);
			logic [DUTY_W-1:0] exp_duty;
			if (duty_fifo.size() == 0) begin
				$error("duty: no transaction expected, actual %0d", got);
				errors++;
			end else begin
				exp_duty = duty_fifo.pop_front();
				checked++;
				if (got !== exp_duty) begin
					$error("duty mismatch: expected %0d, actual %0d", exp_duty, got);
					errors++;
				end
			end
		endfunction

		function int pending();
			return duty_fifo.size();
		endfunction
	endclass

	logic                clk;
	logic                arst_n     = 1'b0;
	logic                cfg_wen    = 1'b0;
	logic [1:0]          cfg_idx    = '0;
	logic [CFG_W-1:0]    cfg_data   = '0;
	logic                item_valid = 1'b0;
	logic                item_stall;
	logic [TIME_W-1:0]   time_us    = '0;
	logic                duty_valid;
	logic                duty_stall = 1'b0;
	logic [DUTY_W-1:0]   duty;

	duty_scoreboard sb;
	int item_gap_pct  = 0;
	int duty_hold_pct = 0;
	int hold_reqs     = 0;
	int hold_seen     = 0;
	int hold_left     = 0;
	int n_settings    = 0;

	sine_modulated_led_duty_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.time_us    (time_us),
		.duty_valid (duty_valid),
		.duty_stall (duty_stall),
		.duty       (duty)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog
	initial begin
		#(12 * 300000);
		$display("tb_top NOT OK");
		$finish;
	end

	// Long hold requests are picked up on the rising edge; the count runs down on the falling edge
	always @(posedge clk) begin
		if (hold_seen != hold_reqs) begin
			hold_seen = hold_reqs;
			hold_left = LONG_HOLD;
		end
	end

	// Result side back-pressure
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			duty_stall <= 1'b1;
		end else begin
			duty_stall <= ($urandom_range(99) < duty_hold_pct);
		end
	end

	// Transaction monitor on both channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall) sb.note_item(time_us);
			if (duty_valid && !duty_stall) sb.check_duty(duty);
		end
	end

	// All tasks start and end on a falling edge; a write clears cfg_wen again and idles before it returns
	task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] data);
		cfg_wen  <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_wen  <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_regs(input logic [CFG_W-1:0] level, input logic [CFG_W-1:0] per,
			input logic [CFG_W-1:0] mode);
		write_reg(REG_DUTY_LEVEL, level);
		write_reg(REG_PERIOD_MS, per);
		write_reg(REG_SINE_MODE, mode);
		n_settings++;
	endtask

	task automatic send_item(input logic [TIME_W-1:0] t_us);
		int gap;
		gap = ($urandom_range(99) < item_gap_pct) ? $urandom_range(1, 4) : 0;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		time_us    <= t_us;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		item_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Full-width noise, times inside the first periods, and times at period edges, quarter and half points
	function automatic logic [TIME_W-1:0] rand_time(input logic [PERIOD_W-1:0] per_ms);
		logic [63:0] per_us, base;
		int pick;
		per_us = (per_ms == 0) ? 64'd1000 : 64'(per_ms) * MS_TO_US;
		pick   = $urandom_range(9);
		if (pick < 4) begin
			base = {$urandom(), $urandom()};
		end else if (pick < 7) begin
			base = 64'($urandom_range(0, 32'(per_us * 3)));
		end else begin
			base = 64'($urandom_range(0, 1 << 20)) * per_us;
			case ($urandom_range(4))
				0: base = base + per_us - 1;
				1: base = base + 1;
				2: base = base + per_us / 4;
				3: base = base + per_us / 2;
				default: ;
			endcase
		end
		return base[TIME_W-1:0];
	endfunction

	task automatic run_phase(input int n_items, input bit long_hold, input bit mid_drain);
		if (long_hold) hold_reqs++;
		for (int i = 0; i < n_items; i++) begin
			send_item(rand_time(sb.cfg_period_ms));
			if (mid_drain && i == n_items / 2) wait_idle();
		end
		wait_idle();
	endtask

	initial begin
		sb = new();
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset values: constant mode, level zero
		send_item('0);
		send_item({TIME_W{1'b1}});
		wait_idle();

		// Full level with wide data, shortest period, quadrant points and wrap
		set_regs(16'hFFFF, 16'd1, 16'hFFFF);
		write_reg(REG_NONE, 16'h1234);
		send_item(63'd0);
		send_item(63'd250);
		send_item(63'd500);
		send_item(63'd750);
		send_item(63'd999);
		send_item(63'd1000);
		send_item({TIME_W{1'b1}});
		wait_idle();

		// Longest period
		write_reg(REG_PERIOD_MS, 16'hFFFF);
		send_item(63'd0);
		send_item(63'd16383750);
		send_item(63'd65534999);
		send_item({TIME_W{1'b1}});
		wait_idle();

		// Zero period in sine mode gives the constant level
		set_regs(16'h0A5B, 16'd0, 16'd1);
		send_item(rand_time(16'd0));
		send_item(rand_time(16'd0));
		wait_idle();

		// Constant mode with a period set, mode bit masked from wide data
		set_regs(16'h1555, 16'd7, 16'hFFFE);
		send_item(63'd1750);
		send_item(rand_time(16'd7));
		wait_idle();

		// Zero level in sine mode, upper data bits set
		set_regs(16'hE000, 16'd3, 16'd1);
		send_item(63'd750);
		wait_idle();

		// Sender idles lightly, receiver heavily
		item_gap_pct  = 18;
		duty_hold_pct = 84;
		set_regs(16'h1FFF, 16'($urandom_range(1, 20)), 16'($urandom) | 16'd1);
		run_phase(80, 1'b0, 1'b0);
		set_regs(16'($urandom), 16'hFFFF, 16'd1);
		run_phase(80, 1'b0, 1'b0);

		// The other way round
		item_gap_pct  = 84;
		duty_hold_pct = 18;
		set_regs(16'($urandom), 16'($urandom), 16'($urandom) & 16'hFFFE);
		run_phase(80, 1'b0, 1'b0);
		set_regs(16'($urandom), 16'd1, 16'd1);
		run_phase(80, 1'b0, 1'b0);

		// No idling: long receiver hold to back up the pipe, then a mid-phase drain
		item_gap_pct  = 0;
		duty_hold_pct = 0;
		set_regs(16'h1FFF, 16'($urandom_range(1, 65535)), 16'd1);
		run_phase(100, 1'b1, 1'b0);
		set_regs(16'($urandom), 16'($urandom_range(1, 500)), 16'($urandom) | 16'd1);
		run_phase(80, 1'b0, 1'b1);

		wait_idle();
		repeat (LATENCY + 10) @(negedge clk);
		$display("Checked %0d duty words over %0d register settings,", sb.checked, n_settings);
		$display("constant and sine modes, zero and extreme periods, stalls on both sides.");
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/smld_pkg.sv
hdl/smld_rdiv.sv
hdl/smld_sin.sv
hdl/sine_modulated_led_duty_core.sv
tb/sv/tb_top.sv
